### hdl/dnsrap_pkg.sv
// dnsrap_pkg: types and constants of the DNS response address parser.
// Holds the item structs, parse phase enum, state struct and protocol codes.
// No dependencies.
`timescale 1ns / 1ps

package dnsrap_pkg;

    localparam int MAX_PACKET_BYTES_DEF = 2048;

    // Header byte positions of interest
    localparam int POS_QDCOUNT_LO = 5;
    localparam int POS_ANCOUNT_LO = 7;
    localparam int POS_HEADER_END = 11;

    localparam logic [7:0]  NAME_PTR_MARK = 8'hc0;
    localparam logic [15:0] RR_TYPE_A     = 16'h0001;
    localparam logic [15:0] RR_TYPE_CNAME = 16'h0005;
    localparam logic [15:0] QD_COUNT_ONE  = 16'h0001;

    localparam logic [15:0] QTAIL_BYTES   = 16'd4;
    localparam logic [15:0] QTYPE_LEFT    = 16'd2;
    localparam logic [15:0] TYPE_BYTES    = 16'd2;
    localparam logic [15:0] RR_REST_BYTES = 16'd8;
    localparam logic [15:0] ADDR_BYTES    = 16'd4;

    typedef enum logic [1:0] {
        ST_IGNORED   = 2'd0,
        ST_NO_ANSWER = 2'd1,
        ST_FOUND     = 2'd2,
        ST_NO_ADDR   = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        PH_HEADER = 4'd0,
        PH_QNAME  = 4'd1,
        PH_QTAIL  = 4'd2,
        PH_ANAME  = 4'd3,
        PH_APTR   = 4'd4,
        PH_ARUN   = 4'd5,
        PH_ATYPE  = 4'd6,
        PH_CREST  = 4'd7,
        PH_CDATA  = 4'd8,
        PH_AREST  = 4'd9,
        PH_AADDR  = 4'd10,
        PH_DONE   = 4'd11
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] address;
    } result_t;

    typedef struct packed {
        phase_t      parse_phase;
        logic [15:0] field_bytes_left;
        logic [15:0] word_assembly;
        logic        header_valid;
        logic [31:0] found_address;
        logic [1:0]  verdict;
    } parse_state_t;

    localparam parse_state_t PARSE_RESET = '{
        parse_phase:      PH_HEADER,
        field_bytes_left: 16'd0,
        word_assembly:    16'd0,
        header_valid:     1'b0,
        found_address:    32'd0,
        verdict:          2'd0
    };

endpackage

### hdl/dnsrap_step.sv
// dnsrap_step: combinational parser step for one payload byte.
// Gives the next parse state and, on the last byte, the verdict.
// Depends on dnsrap_pkg.
`timescale 1ns / 1ps

module dnsrap_step #(
    parameter int MAX_PACKET_BYTES = dnsrap_pkg::MAX_PACKET_BYTES_DEF,
    localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1)
) (
    input  dnsrap_pkg::parse_state_t state,
    input  logic [POS_W-1:0]         position,
    input  dnsrap_pkg::item_t        item,
    output dnsrap_pkg::parse_state_t state_next,
    output logic [POS_W-1:0]         position_next,
    output dnsrap_pkg::result_t      result
);

    dnsrap_pkg::parse_state_t st_c;
    logic [15:0] wa;
    logic [15:0] fbl_dec;
    logic        run;
    logic [1:0]  status;

    assign run     = position < POS_W'(MAX_PACKET_BYTES);
    assign wa      = {state.word_assembly[7:0], item.data_byte};
    assign fbl_dec = (state.field_bytes_left != 16'd0) ?
                     state.field_bytes_left - 16'd1 : 16'd0;

    always_comb
    begin
        st_c = state;
        if (run)
        begin
            st_c.word_assembly = wa;
            case (state.parse_phase)
                dnsrap_pkg::PH_HEADER:
                begin
                    if (position == POS_W'(dnsrap_pkg::POS_QDCOUNT_LO))
                        st_c.header_valid = (wa == dnsrap_pkg::QD_COUNT_ONE);
                    if (position == POS_W'(dnsrap_pkg::POS_ANCOUNT_LO))
                    begin
                        if (!state.header_valid)
                        begin
                            st_c.verdict     = dnsrap_pkg::ST_IGNORED;
                            st_c.parse_phase = dnsrap_pkg::PH_DONE;
                        end
                        else if (wa == 16'd0)
                        begin
                            st_c.verdict     = dnsrap_pkg::ST_NO_ANSWER;
                            st_c.parse_phase = dnsrap_pkg::PH_DONE;
                        end
                    end
                    if (position == POS_W'(dnsrap_pkg::POS_HEADER_END))
                        st_c.parse_phase = dnsrap_pkg::PH_QNAME;
                end
                dnsrap_pkg::PH_QNAME:
                begin
                    if (item.data_byte == 8'd0)
                    begin
                        st_c.parse_phase      = dnsrap_pkg::PH_QTAIL;
                        st_c.field_bytes_left = dnsrap_pkg::QTAIL_BYTES;
                    end
                end
                dnsrap_pkg::PH_QTAIL:
                begin
                    st_c.field_bytes_left = fbl_dec;
                    // question type complete when two bytes remain
                    if (fbl_dec == dnsrap_pkg::QTYPE_LEFT && wa != dnsrap_pkg::RR_TYPE_A)
                    begin
                        st_c.verdict     = dnsrap_pkg::ST_IGNORED;
                        st_c.parse_phase = dnsrap_pkg::PH_DONE;
                    end
                    else if (fbl_dec == 16'd0)
                        st_c.parse_phase = dnsrap_pkg::PH_ANAME;
                end
                dnsrap_pkg::PH_ANAME:
                begin
                    if (item.data_byte == dnsrap_pkg::NAME_PTR_MARK)
                        st_c.parse_phase = dnsrap_pkg::PH_APTR;
                    else if (item.data_byte == 8'd0)
                    begin
                        st_c.parse_phase      = dnsrap_pkg::PH_ATYPE;
                        st_c.field_bytes_left = dnsrap_pkg::TYPE_BYTES;
                    end
                    else
                        st_c.parse_phase = dnsrap_pkg::PH_ARUN;
                end
                dnsrap_pkg::PH_APTR:
                begin
                    st_c.parse_phase      = dnsrap_pkg::PH_ATYPE;
                    st_c.field_bytes_left = dnsrap_pkg::TYPE_BYTES;
                end
                dnsrap_pkg::PH_ARUN:
                begin
                    if (item.data_byte == 8'd0)
                    begin
                        st_c.parse_phase      = dnsrap_pkg::PH_ATYPE;
                        st_c.field_bytes_left = dnsrap_pkg::TYPE_BYTES;
                    end
                end
                dnsrap_pkg::PH_ATYPE:
                begin
                    st_c.field_bytes_left = fbl_dec;
                    if (fbl_dec == 16'd0)
                    begin
                        if (wa == dnsrap_pkg::RR_TYPE_CNAME)
                        begin
                            st_c.parse_phase      = dnsrap_pkg::PH_CREST;
                            st_c.field_bytes_left = dnsrap_pkg::RR_REST_BYTES;
                        end
                        else if (wa == dnsrap_pkg::RR_TYPE_A)
                        begin
                            st_c.parse_phase      = dnsrap_pkg::PH_AREST;
                            st_c.field_bytes_left = dnsrap_pkg::RR_REST_BYTES;
                        end
                        else
                        begin
                            st_c.verdict     = dnsrap_pkg::ST_NO_ADDR;
                            st_c.parse_phase = dnsrap_pkg::PH_DONE;
                        end
                    end
                end
                dnsrap_pkg::PH_CREST:
                begin
                    st_c.field_bytes_left = fbl_dec;
                    // last byte of class/TTL/rdlength: wa holds rdlength
                    if (fbl_dec == 16'd0)
                    begin
                        st_c.field_bytes_left = wa;
                        st_c.parse_phase = (wa != 16'd0) ? dnsrap_pkg::PH_CDATA
                                                         : dnsrap_pkg::PH_ANAME;
                    end
                end
                dnsrap_pkg::PH_CDATA:
                begin
                    st_c.field_bytes_left = fbl_dec;
                    if (fbl_dec == 16'd0)
                        st_c.parse_phase = dnsrap_pkg::PH_ANAME;
                end
                dnsrap_pkg::PH_AREST:
                begin
                    st_c.field_bytes_left = fbl_dec;
                    if (fbl_dec == 16'd0)
                    begin
                        st_c.parse_phase      = dnsrap_pkg::PH_AADDR;
                        st_c.field_bytes_left = dnsrap_pkg::ADDR_BYTES;
                        st_c.found_address    = 32'd0;
                    end
                end
                dnsrap_pkg::PH_AADDR:
                begin
                    st_c.found_address    = {state.found_address[23:0], item.data_byte};
                    st_c.field_bytes_left = fbl_dec;
                    if (fbl_dec == 16'd0)
                    begin
                        st_c.verdict     = dnsrap_pkg::ST_FOUND;
                        st_c.parse_phase = dnsrap_pkg::PH_DONE;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (st_c.parse_phase == dnsrap_pkg::PH_DONE)
            status = st_c.verdict;
        else if (st_c.parse_phase >= dnsrap_pkg::PH_ANAME &&
                 st_c.parse_phase <= dnsrap_pkg::PH_AREST)
            status = dnsrap_pkg::ST_NO_ADDR;
        else
            status = dnsrap_pkg::ST_IGNORED;

        result.status  = status;
        result.address = (status == dnsrap_pkg::ST_FOUND) ? st_c.found_address : 32'd0;

        // the last byte closes the payload and rearms the parser
        if (item.last_byte)
        begin
            state_next    = dnsrap_pkg::PARSE_RESET;
            position_next = '0;
        end
        else
        begin
            state_next    = st_c;
            position_next = run ? position + POS_W'(1) : position;
        end
    end

endmodule

### hdl/dnsrap_out.sv
// dnsrap_out: result register between the parser and the result channel.
// Holds one verdict until taken; frees itself in the cycle it is taken.
// Depends on dnsrap_pkg.
`timescale 1ns / 1ps

module dnsrap_out (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  dnsrap_pkg::result_t load_data,
    output logic                space,
    output logic                result_valid,
    input  logic                result_ready,
    output dnsrap_pkg::result_t result
);

    logic                valid_reg;
    logic                valid_next;
    dnsrap_pkg::result_t data_reg;

    assign space      = !valid_reg || result_ready;
    assign valid_next = load || (valid_reg && !result_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= load_data;
    end

    assign result_valid = valid_reg;
    assign result       = data_reg;

endmodule

### hdl/dns_response_address_parser.sv
// DNS response address parser: takes a UDP payload one byte per item and
// gives one verdict item (status, IPv4 address) for the byte marked last.
// The parser takes one byte every cycle unless held off: each byte advances
// the parse state registers through one step of logic, and the verdict is
// written into a result register by the clock edge that accepts the last
// byte. Input is held off only while that result register is full and not
// being taken. Bytes beyond MAX_PACKET_BYTES are accepted but not parsed.
// Depends on dnsrap_pkg, dnsrap_step, dnsrap_out.
`timescale 1ns / 1ps

module dns_response_address_parser #(
    parameter int MAX_PACKET_BYTES = dnsrap_pkg::MAX_PACKET_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  dnsrap_pkg::item_t   item,
    output logic                result_valid,
    input  logic                result_ready,
    output dnsrap_pkg::result_t result
);

    localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);

    dnsrap_pkg::parse_state_t state_reg;
    dnsrap_pkg::parse_state_t state_next;
    logic [POS_W-1:0]         position_reg;
    logic [POS_W-1:0]         position_next;
    dnsrap_pkg::result_t      step_result;
    logic                     accept;
    logic                     space;

    assign item_ready = space;
    assign accept     = item_valid && space;

    dnsrap_step #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_step (
        .state         (state_reg),
        .position      (position_reg),
        .item          (item),
        .state_next    (state_next),
        .position_next (position_next),
        .result        (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= dnsrap_pkg::PARSE_RESET;
            position_reg <= '0;
        end
        else if (accept)
        begin
            state_reg    <= state_next;
            position_reg <= position_next;
        end
    end

    dnsrap_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (accept && item.last_byte),
        .load_data    (step_result),
        .space        (space),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
